### src/bloom_filter_engine_assert.svh
// Assertion macros for the bloom filter engine.
// Each use names the clock and reset low of the file that includes it.
`ifndef BLOOM_FILTER_ENGINE_ASSERT_SVH
`define BLOOM_FILTER_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define BFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bloom_filter_engine: same-cycle check failed");

// Next-cycle implication.
`define BFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bloom_filter_engine: next-cycle check failed");

`endif

### src/bfe_pkg.sv
package bfe_pkg;

  localparam int FILTER_BITS_DEF = 1024 * 1024;
  localparam int MAX_HASHES_DEF  = 16;
  localparam int KEY_W           = 64;
  localparam int WORD_W          = 64;
  localparam int CFG_W           = 5;

  localparam logic [CFG_W-1:0] NUM_HASHES_RST = 5'd3;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WB0,
    ST_WB1
  } bfe_state_t;

  // Control part of one queued operation.
  typedef struct packed {
    logic valid;
    logic cmd;
    logic two;   // probes reach into the following word
  } bfe_op_ctl_t;

  // Back-end status seen by the front end and the top level.
  typedef struct packed {
    logic clearing;
    logic busy;
  } bfe_status_t;

endpackage

### src/bfe_front.sv
module bfe_front #(
  parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF,
  localparam int DEPTH      = FILTER_BITS / bfe_pkg::WORD_W,
  localparam int WADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [bfe_pkg::KEY_W-1:0]           in_key_hash,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfe_pkg::CFG_W-1:0]           cfg_num_hashes,
  input  bfe_pkg::bfe_status_t                stat,
  output bfe_pkg::bfe_op_ctl_t                op_ctl,
  input  logic                                op_ready,
  output logic [WADDR_W-1:0]                  op_addr0,
  output logic [WADDR_W-1:0]                  op_addr1,
  output logic [bfe_pkg::WORD_W-1:0]          op_mask0,
  output logic [bfe_pkg::WORD_W-1:0]          op_mask1
);
  import bfe_pkg::*;

  localparam int K_W = $clog2(MAX_HASHES + 1);

  logic [CFG_W-1:0]    num_hashes_r;
  logic [K_W-1:0]      k_sat;
  logic [WORD_W-1:0]   ones;
  logic [2*WORD_W-1:0] span;
  logic [WADDR_W-1:0]  addr0, addr1;
  logic [WORD_W-1:0]   mask0, mask1;
  logic                two;

  // two-entry queue
  logic                q_cmd_r   [2];
  logic                q_two_r   [2];
  logic [WADDR_W-1:0]  q_addr0_r [2];
  logic [WADDR_W-1:0]  q_addr1_r [2];
  logic [WORD_W-1:0]   q_mask0_r [2];
  logic [WORD_W-1:0]   q_mask1_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r, count_nxt;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_hashes_r <= NUM_HASHES_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_hashes_r <= cfg_num_hashes;
    end
  end

  // probe count, saturated
  always_comb begin
    if (int'(num_hashes_r) > MAX_HASHES) begin
      k_sat = K_W'(MAX_HASHES);
    end else begin
      k_sat = K_W'(num_hashes_r);
    end
  end

  // run of k ones, placed at the bit offset within the first word
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      ones[i] = (i < int'(k_sat));
    end
    span = {{WORD_W{1'b0}}, ones} << in_key_hash[5:0];
  end

  always_comb begin
    if (DEPTH == 1) begin
      addr0 = '0;
      addr1 = '0;
      mask0 = span[WORD_W-1:0] | span[2*WORD_W-1:WORD_W];
      mask1 = '0;
      two   = 1'b0;
    end else begin
      addr0 = WADDR_W'(in_key_hash >> 6);
      addr1 = WADDR_W'(addr0 + 1'b1);
      mask0 = span[WORD_W-1:0];
      mask1 = span[2*WORD_W-1:WORD_W];
      two   = |mask1;
    end
  end

  assign in_ready = !stat.clearing && (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = op_ctl.valid && op_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r]   <= in_cmd;
      q_two_r[wr_ptr_r]   <= two;
      q_addr0_r[wr_ptr_r] <= addr0;
      q_addr1_r[wr_ptr_r] <= addr1;
      q_mask0_r[wr_ptr_r] <= mask0;
      q_mask1_r[wr_ptr_r] <= mask1;
    end
  end

  assign op_ctl.valid = (count_r != 2'd0);
  assign op_ctl.cmd   = q_cmd_r[rd_ptr_r];
  assign op_ctl.two   = q_two_r[rd_ptr_r];
  assign op_addr0     = q_addr0_r[rd_ptr_r];
  assign op_addr1     = q_addr1_r[rd_ptr_r];
  assign op_mask0     = q_mask0_r[rd_ptr_r];
  assign op_mask1     = q_mask1_r[rd_ptr_r];

endmodule

### src/bfe_back.sv
module bfe_back #(
  parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
  localparam int DEPTH      = FILTER_BITS / bfe_pkg::WORD_W,
  localparam int WADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfe_pkg::bfe_op_ctl_t                op_ctl,
  output logic                                op_ready,
  input  logic [WADDR_W-1:0]                  op_addr0,
  input  logic [WADDR_W-1:0]                  op_addr1,
  input  logic [bfe_pkg::WORD_W-1:0]          op_mask0,
  input  logic [bfe_pkg::WORD_W-1:0]          op_mask1,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_may_contain,
  output bfe_pkg::bfe_status_t                stat
);
  import bfe_pkg::*;

  bfe_state_t          state_r, state_nxt;
  logic [WADDR_W-1:0]  clr_cnt_r;
  logic                cmd_r, two_r, hit_r;
  logic [WADDR_W-1:0]  addr0_r, addr1_r;
  logic [WORD_W-1:0]   mask0_r, mask1_r;

  logic [WORD_W-1:0]   bit_store_r [DEPTH];
  logic [WORD_W-1:0]   rd_data_r;

  logic                out_valid_r, out_may_r;
  logic                out_free;
  logic                rd_en, we, deliver, res;
  logic [WADDR_W-1:0]  rd_addr, wa;
  logic [WORD_W-1:0]   wd;
  logic                hit0, hit1, clr_last;

  assign out_free = !out_valid_r || out_ready;
  assign hit0     = ((rd_data_r & mask0_r) == mask0_r);
  assign hit1     = ((rd_data_r & mask1_r) == mask1_r);
  assign clr_last = (clr_cnt_r == WADDR_W'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_ctl.valid) begin
          state_nxt = ST_WB0;
        end
      end
      ST_WB0: begin
        if (two_r) begin
          state_nxt = ST_WB1;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WB1: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    op_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = addr1_r;
    we       = 1'b0;
    wa       = addr0_r;
    wd       = rd_data_r | mask0_r;
    deliver  = 1'b0;
    res      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt_r;
        wd = '0;
      end
      ST_IDLE: begin
        op_ready = 1'b1;
        rd_en    = op_ctl.valid;
        rd_addr  = op_addr0;
      end
      ST_WB0: begin
        we = (cmd_r == CMD_ADD);
        if (two_r) begin
          rd_en = 1'b1;
        end else begin
          deliver = out_free;
          res     = (cmd_r == CMD_QUERY) && hit0;
        end
      end
      ST_WB1: begin
        we      = (cmd_r == CMD_ADD);
        wa      = addr1_r;
        wd      = rd_data_r | mask1_r;
        deliver = out_free;
        res     = (cmd_r == CMD_QUERY) && hit_r && hit1;
      end
      default: begin
        op_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= WADDR_W'(clr_cnt_r + 1'b1);
      end
      if (deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && op_ctl.valid) begin
      cmd_r   <= op_ctl.cmd;
      two_r   <= op_ctl.two;
      addr0_r <= op_addr0;
      addr1_r <= op_addr1;
      mask0_r <= op_mask0;
      mask1_r <= op_mask1;
    end
    if (state_r == ST_WB0) begin
      hit_r <= hit0;
    end
    if (deliver) begin
      out_may_r <= res;
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      bit_store_r[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= bit_store_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_may_contain = out_may_r;
  assign stat.clearing   = (state_r == ST_CLEAR);
  assign stat.busy       = (state_r == ST_WB0) || (state_r == ST_WB1);

endmodule

### src/bloom_filter_engine.sv
// Each item is queued; its first 64-bit word is then read and checked (query)
// or merged and written back (add), and when the probe run crosses into the
// next word, that word follows. The single read-modify-write sequencer, on
// the bit store's one read and one write port, takes one item at a time.
// Reset: synchronous, active low; the bit store is then zeroed one word per
// cycle, all FILTER_BITS/64 words (16384 by default), with in_ready held low.
module bloom_filter_engine #(
  parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF,
  localparam int DEPTH      = FILTER_BITS / bfe_pkg::WORD_W,
  localparam int WADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [bfe_pkg::KEY_W-1:0]    in_key_hash,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_may_contain,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfe_pkg::CFG_W-1:0]    cfg_num_hashes
);
  import bfe_pkg::*;

  // Front end: takes the transfer, saturates the probe count, turns the
  // key into one or two word addresses plus bit masks, and queues them.
  // Back end: clears the store after reset, then runs each queued op as read
  // word / merge and write word (adds) or check (queries), producing may_contain.
  bfe_op_ctl_t        op_ctl;
  bfe_status_t        stat;
  logic               op_ready;
  logic [WADDR_W-1:0] op_addr0, op_addr1;
  logic [WORD_W-1:0]  op_mask0, op_mask1;

  bfe_front #(
    .FILTER_BITS (FILTER_BITS),
    .MAX_HASHES  (MAX_HASHES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key_hash    (in_key_hash),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_num_hashes (cfg_num_hashes),
    .stat           (stat),
    .op_ctl         (op_ctl),
    .op_ready       (op_ready),
    .op_addr0       (op_addr0),
    .op_addr1       (op_addr1),
    .op_mask0       (op_mask0),
    .op_mask1       (op_mask1)
  );

  bfe_back #(
    .FILTER_BITS (FILTER_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_ctl          (op_ctl),
    .op_ready        (op_ready),
    .op_addr0        (op_addr0),
    .op_addr1        (op_addr1),
    .op_mask0        (op_mask0),
    .op_mask1        (op_mask1),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_may_contain (out_may_contain),
    .stat            (stat)
  );

  // Checks: no transfer taken or result shown during the clearing pass,
  // and an op popped from the queue always leaves the sequencer busy.
`include "bloom_filter_engine_assert.svh"

  `BFE_ASSERT_SAME(a_no_in_while_clr, clk, rst_n, stat.clearing, !in_ready)
  `BFE_ASSERT_SAME(a_no_out_while_clr, clk, rst_n, stat.clearing, !out_valid)
  `BFE_ASSERT_NEXT(a_pop_makes_busy, clk, rst_n, op_ctl.valid && op_ready, stat.busy)

endmodule

### test/bfe_answer_check.sv
`timescale 1ns / 100ps
module bfe_answer_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [bfe_pkg::KEY_W-1:0] in_key_hash,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_may_contain,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bfe_pkg::CFG_W-1:0] cfg_num_hashes,
  output int                        pending,
  output int                        failures,
  output int                        hits
);
  import bfe_pkg::*;

  localparam int STORE_WORDS = FILTER_BITS_DEF / WORD_W;
  localparam int POS_W       = $clog2(FILTER_BITS_DEF);

  // Shadow filter, one bit per position, word-organised like the block's store
  bit   [WORD_W-1:0] filter_words [STORE_WORDS];
  logic [CFG_W-1:0]  hash_count;
  logic              expected_answers [$];
  int                fail_tally;
  int                hit_tally;

  // Applies one key to the shadow filter and returns the answer it should give
  function automatic logic membership_answer(input logic cmd, input logic [KEY_W-1:0] key);
    int unsigned       probes;
    int unsigned       i;
    logic [POS_W-1:0]  pos;
    logic              all_set;
    probes  = (hash_count > MAX_HASHES_DEF) ? MAX_HASHES_DEF : hash_count;
    all_set = 1'b1;
    for (i = 0; i < probes; i++) begin
      pos = key[POS_W-1:0] + POS_W'(i);   // wraps at the top of the store
      if (cmd == CMD_ADD)
        filter_words[pos[POS_W-1:6]][pos[5:0]] = 1'b1;
      else if (!filter_words[pos[POS_W-1:6]][pos[5:0]])
        all_set = 1'b0;
    end
    return (cmd == CMD_ADD) ? 1'b0 : all_set;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      foreach (filter_words[w])
        filter_words[w] = '0;
      hash_count = NUM_HASHES_RST;
      expected_answers.delete();
      fail_tally = 0;
      hit_tally  = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        hash_count = cfg_num_hashes;
      if (in_valid && in_ready)
        expected_answers.push_back(membership_answer(in_cmd, in_key_hash));
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result transfer: may_contain %0b", out_may_contain);
          fail_tally++;
        end else begin
          want = expected_answers.pop_front();
          if (out_may_contain !== want) begin
            $error("may_contain: expected %0b, actual %0b", want, out_may_contain);
            fail_tally++;
          end
          if (want)
            hit_tally++;
        end
      end
    end
    pending  <= expected_answers.size();
    failures <= fail_tally;
    hits     <= hit_tally;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import bfe_pkg::*;

  // Room for the clearing pass after reset plus a slow correct run of ~860
  // items with worst gaps and stalls.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int POS_W           = $clog2(FILTER_BITS_DEF);
  localparam logic [POS_W-1:0] POS_TOP = '1;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_cmd          = CMD_ADD;
  logic [KEY_W-1:0] in_key_hash     = '0;
  logic             out_ready       = 1'b1;
  logic             cfg_valid       = 1'b0;
  logic [CFG_W-1:0] cfg_num_hashes  = '0;
  logic             in_ready;
  logic             out_valid;
  logic             out_may_contain;
  logic             cfg_ready;

  int pending;
  int failures;
  int hits;

  // Idling control: calm switches all idling off for the closing phase
  logic        calm         = 1'b0;
  logic        tx_bursty    = 1'b0;
  int          tx_mode_left = 0;
  logic        rx_bursty    = 1'b0;
  int          rx_mode_left = 0;
  int          rx_hold      = 0;
  int unsigned cycle_count  = 0;

  int adds_sent     = 0;
  int queries_sent  = 0;
  int settings_used = 0;

  // Recently added keys; queries draw on these so that many of them can hit
  logic [KEY_W-1:0] added_keys [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bloom_filter_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key_hash    (in_key_hash),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_may_contain(out_may_contain),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_num_hashes (cfg_num_hashes)
  );

  bfe_answer_check answer_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key_hash    (in_key_hash),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_may_contain(out_may_contain),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_num_hashes (cfg_num_hashes),
    .pending        (pending),
    .failures       (failures),
    .hits           (hits)
  );

  // Watchdog: a stuck handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side back-pressure: stretches with random stall bursts, in which
  // out_ready is held low, alternate with stretches without.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
      rx_hold   <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_bursty    <= 1'($urandom_range(0, 1));
        rx_mode_left <= $urandom_range(30, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (rx_hold != 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= (rx_hold == 1);
      end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
        rx_hold   <= $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // One input transfer, with an optional idle burst before it. Valid is left
  // high afterwards so back-to-back items never drop it within one step.
  task automatic send_key(input logic cmd, input logic [KEY_W-1:0] key);
    if (!calm) begin
      if (tx_mode_left == 0) begin
        tx_bursty    = 1'($urandom_range(0, 1));
        tx_mode_left = $urandom_range(20, 80);
      end else begin
        tx_mode_left--;
      end
      if (tx_bursty && $urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_key_hash <= key;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_ADD)
      adds_sent++;
    else
      queries_sent++;
  endtask

  // Stop sending, wait for every outstanding result, then idle on before returning.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write only once the block has gone quiet
  task automatic write_setting(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid      <= 1'b1;
    cfg_num_hashes <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly adds followed by queries of the same keys; the rest are aliases
  // (same low bits, other high bits), shifted keys that overlap partly, and
  // fresh keys that almost always miss.
  task automatic random_item();
    logic [KEY_W-1:0] key;
    int               pick;
    int               idx;
    pick = $urandom_range(0, 99);
    key  = random_key();
    if (pick < 40 || added_keys.size() == 0) begin
      case ($urandom_range(0, 3))
        0:       key[5:0] = 6'($urandom_range(48, 63));                  // may cross a word
        1:       key[POS_W-1:0] = POS_TOP - POS_W'($urandom_range(0, 20)); // may wrap to bit 0
        default: ;
      endcase
      added_keys.push_back(key);
      if (added_keys.size() > 64)
        void'(added_keys.pop_front());
      send_key(CMD_ADD, key);
    end else begin
      idx = $urandom_range(0, added_keys.size() - 1);
      if (pick < 65)
        key = added_keys[idx];
      else if (pick < 75)
        key[POS_W-1:0] = added_keys[idx][POS_W-1:0];
      else if (pick < 88)
        key = added_keys[idx] + KEY_W'($urandom_range(1, 20));
      send_key(CMD_QUERY, key);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] setting;
    int               phase;
    int               n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting of three probes, no register write yet
    send_key(CMD_QUERY, 64'h0);                    // empty filter
    send_key(CMD_ADD,   64'h0);
    send_key(CMD_QUERY, 64'h0);
    send_key(CMD_QUERY, 64'h1);                    // one probe beyond the set run
    send_key(CMD_ADD,   64'hFFFF_FFFF_FFFF_FFFF);  // top of store, wraps to bit 0
    send_key(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(CMD_QUERY, 64'h0000_0000_000F_FFFE);  // run starting one below, overlapping across the wrap
    send_key(CMD_ADD,   64'd62);                   // run crosses into the next word
    send_key(CMD_QUERY, 64'd62);
    send_key(CMD_QUERY, 64'd63);

    // Zero probes: adds change nothing, queries always answer 1
    write_setting(5'd0);
    send_key(CMD_QUERY, 64'h1234_5678_9ABC_DEF0);
    send_key(CMD_ADD,   64'hDEAD_BEEF_0000_4000);

    // Above the maximum: saturates to sixteen probes
    write_setting(5'd31);
    send_key(CMD_ADD,   64'h8000_0000_0000_0100);
    send_key(CMD_QUERY, 64'h8000_0000_0000_0100);
    send_key(CMD_QUERY, 64'h8000_0000_0000_0101);
    write_setting(5'd17);
    send_key(CMD_QUERY, 64'h8000_0000_0000_0100);
    write_setting(5'd16);
    send_key(CMD_ADD,   64'hAAAA_AAAA_AAAA_AAAA);
    send_key(CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);

    write_setting(5'd1);
    send_key(CMD_QUERY, 64'h5555_5555_5555_5555);
    send_key(CMD_ADD,   64'h5555_5555_5555_5555);
    send_key(CMD_QUERY, 64'h5555_5555_5555_5555);

    // Random phases: extremes of num_hashes first, then random settings;
    // the last phase runs with no idling on either side.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       setting = 5'd1;
        1:       setting = 5'd16;
        2:       setting = 5'd31;
        3:       setting = 5'd0;
        4:       setting = 5'd17;
        default: setting = CFG_W'($urandom_range(2, 15));
      endcase
      write_setting(setting);
      if (phase == RANDOM_PHASES - 1)
        calm <= 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == ITEMS_PER_PHASE / 2)
          settle();   // full drain mid-phase, then carry on
        random_item();
      end
    end

    settle();
    repeat (10) @(posedge clk);

    $display("Covered %0d adds and %0d queries over %0d num_hashes settings (0, 1, 16, 17, 31 among them).",
             adds_sent, queries_sent, settings_used);
    $display("%0d queries answered may-contain; word crossing and store wrap exercised.", hits);
    if (pending != 0)
      $error("%0d expected results never arrived", pending);
    if (failures == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
